// ----- rtl/point_in_polygon_crossing_test_assert.svh -----
// ----------------------------------------------------------------------------
// point-in-polygon crossing test: assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during rst
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_CROSSING_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_ASSERT_SVH

// same-cycle implication
`define PIPCT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipct assertion failed");

// next-cycle implication
`define PIPCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipct assertion failed");

`endif

// ----- rtl/pipct_pkg.sv -----
// ----------------------------------------------------------------------------
// pipct_pkg
// shared constants and types of the point-in-polygon crossing test
// ----------------------------------------------------------------------------
`default_nettype none

package pipct_pkg;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_END_X  = 2'd1;
  localparam logic [CFG_DATA_W-1:0] RAY_END_RESET = 32'd8192;

  // request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // crossing count field
  localparam int CROSS_W = 7;
  localparam logic [CROSS_W-1:0] CROSS_MAX = 7'd127;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int LVL_W       = 2;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [LVL_W-1:0] level;
  } pipct_q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/pipct_item_if.sv -----
// ----------------------------------------------------------------------------
// pipct_item_if
// request channel: edge writes and point queries
// ----------------------------------------------------------------------------
`default_nettype none

interface pipct_item_if #(
  parameter int COORD_WIDTH = 16,
  parameter int SLOT_W      = 6
);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic        [SLOT_W-1:0]      edge_slot;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by;

  modport source (output valid, func, edge_slot, ax, ay, bx, by, input ready);
  modport sink   (input valid, func, edge_slot, ax, ay, bx, by, output ready);
endinterface

`default_nettype wire

// ----- rtl/pipct_res_if.sv -----
// ----------------------------------------------------------------------------
// pipct_res_if
// result channel: inside flag and crossing count of one query
// ----------------------------------------------------------------------------
`default_nettype none

interface pipct_res_if;
  import pipct_pkg::*;

  logic               valid;
  logic               ready;
  logic               inside_res;
  logic [CROSS_W-1:0] crossings;

  modport source (output valid, inside_res, crossings, input ready);
  modport sink   (input valid, inside_res, crossings, output ready);
endinterface

`default_nettype wire

// ----- rtl/pipct_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pipct_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface pipct_cfg_if;
  import pipct_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pipct_front.sv -----
// ----------------------------------------------------------------------------
// pipct_front
// accepts requests, drops edge writes to slots past the table, and holds
// the rest in a two-entry queue towards the back end
// ----------------------------------------------------------------------------
`default_nettype none

module pipct_front #(
  parameter int MAX_EDGES   = 64,
  parameter int COORD_WIDTH = 16,
  localparam int SLOT_W     = $clog2(MAX_EDGES)
) (
  input  logic                    clk,
  input  logic                    rst,
  pipct_item_if.sink              req,
  pipct_item_if.source            cmd,
  output pipct_pkg::pipct_q_stat_t q_stat
);
  import pipct_pkg::*;

  typedef struct packed {
    logic                          func;
    logic        [SLOT_W-1:0]      edge_slot;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
  } entry_t;

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [LVL_W-1:0]   level;
  logic               full;
  logic               empty;
  logic               slot_ok;
  logic               keep;
  logic               push;
  logic               pop;
  entry_t             head;

  // classify: only in-range writes and all queries go on
  assign slot_ok = ({1'b0, req.edge_slot} < (SLOT_W + 1)'(MAX_EDGES));
  assign keep    = (req.func == FUNC_QUERY) || slot_ok;

  assign full      = (level == LVL_W'(QUEUE_DEPTH));
  assign empty     = (level == '0);
  assign req.ready = !full;
  assign push      = req.valid && req.ready && keep;
  assign pop       = cmd.valid && cmd.ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{func: req.func, edge_slot: req.edge_slot,
                         ax: req.ax, ay: req.ay, bx: req.bx, by: req.by};
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

  // head of queue to the back end
  assign head          = slots[rd_ptr];
  assign cmd.valid     = !empty;
  assign cmd.func      = head.func;
  assign cmd.edge_slot = head.edge_slot;
  assign cmd.ax        = head.ax;
  assign cmd.ay        = head.ay;
  assign cmd.bx        = head.bx;
  assign cmd.by        = head.by;

  assign q_stat = '{push: push, pop: pop, level: level};

endmodule

`default_nettype wire

// ----- rtl/pipct_back.sv -----
// ----------------------------------------------------------------------------
// pipct_back
// edge table and crossing walker: one stored edge enters the orientation
// pipeline per cycle, the count lands in a result register
// ----------------------------------------------------------------------------
`default_nettype none

module pipct_back #(
  parameter int MAX_EDGES   = 64,
  parameter int COORD_WIDTH = 16,
  localparam int SLOT_W     = $clog2(MAX_EDGES),
  localparam int NW         = $clog2(MAX_EDGES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  pipct_item_if.sink                    cmd,
  pipct_res_if.source                   rsp,
  input  logic        [NW-1:0]          edge_count,
  input  logic signed [COORD_WIDTH-1:0] ray_end_x
);
  import pipct_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
  } edge_t;

  edge_t edge_mem [MAX_EDGES];

  logic [1:0]           state;
  logic [NW-1:0]        idx;
  logic [NW-1:0]        n_edges;
  logic                 issue;
  logic                 v1, v2, v3;
  logic                 pipe_busy;

  // query operands
  logic signed [CW-1:0] qpx, qpy, qrx;
  logic                 rp_neg, rp_zero;
  logic signed [DW-1:0] rp_c;

  // stage 1: edge read
  edge_t                rd_q;

  // stage 2: differences
  logic signed [DW-1:0] ex_c, ey_c, dpy_c, dpx_c, drx_c, day_c, dby_c;
  logic signed [DW-1:0] ex_q, ey_q, dpy_q, dpx_q, drx_q;
  logic                 la_c, lb_c, cab2;

  // stage 3: products
  logic signed [PW-1:0] p1, p2, p3;
  logic                 cab3;
  logic        [PW:0]   dp_c, dr_c;
  logic                 hit_c;

  // count
  logic [CROSS_W-1:0]   cnt;
  logic                 par;

  // result register
  logic                 res_valid;
  logic                 res_inside;
  logic [CROSS_W-1:0]   res_cross;

  function automatic logic lft(input logic neg_a, input logic zero_a,
                               input logic neg_b, input logic zero_b);
    return zero_a || zero_b || (neg_a == neg_b);
  endfunction

  assign cmd.ready = (state == ST_IDLE);
  assign issue     = (state == ST_WALK) && (idx < n_edges);
  assign pipe_busy = v1 || v2 || v3;
  assign rp_c      = {ray_end_x[CW-1], ray_end_x} - {cmd.ax[CW-1], cmd.ax};

  // edge table write and walker read
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready && (cmd.func == FUNC_WRITE)) begin
      edge_mem[cmd.edge_slot] <= '{ax: cmd.ax, ay: cmd.ay, bx: cmd.bx, by: cmd.by};
    end
    if (issue) begin
      rd_q <= edge_mem[idx[SLOT_W-1:0]];
    end
  end

  // differences against the stored edge
  always_comb begin
    ex_c  = {rd_q.bx[CW-1], rd_q.bx} - {rd_q.ax[CW-1], rd_q.ax};
    ey_c  = {rd_q.by[CW-1], rd_q.by} - {rd_q.ay[CW-1], rd_q.ay};
    dpy_c = {qpy[CW-1], qpy} - {rd_q.ay[CW-1], rd_q.ay};
    dpx_c = {qpx[CW-1], qpx} - {rd_q.ax[CW-1], rd_q.ax};
    drx_c = {qrx[CW-1], qrx} - {rd_q.ax[CW-1], rd_q.ax};
    day_c = {rd_q.ay[CW-1], rd_q.ay} - {qpy[CW-1], qpy};
    dby_c = {rd_q.by[CW-1], rd_q.by} - {qpy[CW-1], qpy};
    la_c  = lft(rp_neg, rp_zero, day_c[DW-1], day_c == '0);
    lb_c  = lft(rp_neg, rp_zero, dby_c[DW-1], dby_c == '0);
  end

  always_ff @(posedge clk) begin
    ex_q  <= ex_c;
    ey_q  <= ey_c;
    dpy_q <= dpy_c;
    dpx_q <= dpx_c;
    drx_q <= drx_c;
    cab2  <= la_c ^ lb_c;
  end

  // orientation products of the edge line
  always_ff @(posedge clk) begin
    p1   <= ex_q * dpy_q;
    p2   <= ey_q * dpx_q;
    p3   <= ey_q * drx_q;
    cab3 <= cab2;
  end

  // sides of point and ray end, zero counts as left
  assign dp_c  = {p1[PW-1], p1} - {p2[PW-1], p2};
  assign dr_c  = {p1[PW-1], p1} - {p3[PW-1], p3};
  assign hit_c = v3 && cab3 && (dp_c[PW] != dr_c[PW]);

  // query operand capture
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready && (cmd.func == FUNC_QUERY)) begin
      qpx     <= cmd.ax;
      qpy     <= cmd.ay;
      qrx     <= ray_end_x;
      n_edges <= edge_count;
      rp_neg  <= rp_c[DW-1];
      rp_zero <= (rp_c == '0);
    end
  end

  // walker control, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      cnt       <= '0;
      par       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      if (issue) idx <= idx + 1'b1;
      if (hit_c) begin
        cnt <= (cnt == CROSS_MAX) ? CROSS_MAX : cnt + 1'b1;
        par <= !par;
      end
      if (rsp.valid && rsp.ready && (state != ST_DONE)) res_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (cmd.valid && (cmd.func == FUNC_QUERY)) begin
            idx   <= '0;
            cnt   <= '0;
            par   <= 1'b0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!issue && !pipe_busy) state <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || rsp.ready) begin
            res_valid  <= 1'b1;
            res_inside <= par;
            res_cross  <= cnt;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid      = res_valid;
  assign rsp.inside_res = res_inside;
  assign rsp.crossings  = res_cross;

endmodule

`default_nettype wire

// ----- rtl/point_in_polygon_crossing_test.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// edge table with a crossing-number point-in-polygon query
// ----------------------------------------------------------------------------
// Channels: req carries edge writes (func write: edge ax,ay-bx,by into
// edge_slot) and point queries (func query: point ax,ay). rsp returns one
// inside_res/crossings result per query and nothing for writes. cfg writes
// edge_count (register 0) and ray_end_x (register 1); the user is to do so
// only while idle, which the block itself does not enforce. Requests pass
// a two-entry queue; the back end takes one at a time. An edge write is
// taken while the back end is idle and leaves it idle. A query walks
// edge_count slots through the orientation pipeline at one edge per cycle;
// the back end takes its next request once the query's count has gone into
// the result register.
// Writes to a slot past the table are taken and dropped.
// Reset clears the queue, the walker and the result register, sets
// edge_count to 0 and ray_end_x to 8192; the edge table holds nothing valid
// until written. While rsp is stalled the result is held, the queue keeps
// taking requests and edge writes still go through; the next query walks
// and then waits for the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_crossing_test #(
  parameter int MAX_EDGES   = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  pipct_item_if.sink  req,
  pipct_res_if.source rsp,
  pipct_cfg_if.sink   cfg
);
  import pipct_pkg::*;

  localparam int SLOT_W = $clog2(MAX_EDGES);
  localparam int NW     = $clog2(MAX_EDGES + 1);

  logic        [NW-1:0]          edge_count;
  logic signed [COORD_WIDTH-1:0] ray_end_x;
  pipct_q_stat_t                 q_stat;

  pipct_item_if #(.COORD_WIDTH(COORD_WIDTH), .SLOT_W(SLOT_W)) cmd_ch ();

  // configuration registers, edge count clamped to the table size
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      ray_end_x  <= RAY_END_RESET[COORD_WIDTH-1:0];
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_EDGE_COUNT: begin
          edge_count <= (cfg.data > CFG_DATA_W'(MAX_EDGES)) ?
                        NW'(MAX_EDGES) : cfg.data[NW-1:0];
        end
        REG_RAY_END_X: begin
          ray_end_x <= cfg.data[COORD_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // front end: accept, classify, queue
  pipct_front #(.MAX_EDGES(MAX_EDGES), .COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd_ch),
    .q_stat (q_stat)
  );

  // back end: edge table and crossing walker
  pipct_back #(.MAX_EDGES(MAX_EDGES), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp),
    .edge_count (edge_count),
    .ray_end_x  (ray_end_x)
  );

  // checks
`include "point_in_polygon_crossing_test_assert.svh"

  `PIPCT_ASSERT_IMPLY(a_parity, rsp.valid && (rsp.crossings != CROSS_MAX), rsp.inside_res == rsp.crossings[0])
  `PIPCT_ASSERT_NEXT(a_q_fill, q_stat.push && !q_stat.pop, q_stat.level == $past(q_stat.level) + 1'b1)
  `PIPCT_ASSERT_NEXT(a_q_drain, q_stat.pop && !q_stat.push, q_stat.level == $past(q_stat.level) - 1'b1)
  `PIPCT_ASSERT_IMPLY(a_q_bound, 1'b1, q_stat.level <= LVL_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire
